// File: hw/rtl/hsip_pkg.sv
// HalfSipHash-2-4 shared types, constants and round functions.
package hsip_pkg;

  localparam logic [31:0] SIP_C0    = 32'h6c796765;
  localparam logic [31:0] SIP_C1    = 32'h74656462;
  localparam int unsigned LEN_SHIFT = 24;
  localparam logic [31:0] FIN_XOR   = 32'h0000_00ff;

  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] v2;
    logic [31:0] v3;
  } sip_state_t;

  typedef struct packed {
    sip_state_t  st;
    logic        extra;
    logic [7:0]  len;
  } fin_req_t;

  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned b);
    return (x << b) | (x >> (32 - b));
  endfunction

  function automatic sip_state_t sip_round(sip_state_t s);
    sip_state_t r;
    r = s;
    r.v0 = r.v0 + r.v1; r.v1 = rotl(r.v1, 5);  r.v1 = r.v1 ^ r.v0; r.v0 = rotl(r.v0, 16);
    r.v2 = r.v2 + r.v3; r.v3 = rotl(r.v3, 8);  r.v3 = r.v3 ^ r.v2;
    r.v0 = r.v0 + r.v3; r.v3 = rotl(r.v3, 7);  r.v3 = r.v3 ^ r.v0;
    r.v2 = r.v2 + r.v1; r.v1 = rotl(r.v1, 13); r.v1 = r.v1 ^ r.v2; r.v2 = rotl(r.v2, 16);
    return r;
  endfunction

  function automatic sip_state_t sip_double(sip_state_t s);
    return sip_round(sip_round(s));
  endfunction

  function automatic sip_state_t sip_compress(sip_state_t s, logic [31:0] m);
    sip_state_t r;
    r = s;
    r.v3 = r.v3 ^ m;
    r = sip_double(r);
    r.v0 = r.v0 ^ m;
    return r;
  endfunction

  function automatic logic [31:0] len_block(logic [7:0] len);
    return 32'(len) << LEN_SHIFT;
  endfunction

endpackage

// File: hw/rtl/hsip_fin.sv
// HalfSipHash finalisation pipeline: trailing length block, v2 flip, four rounds.
module hsip_fin import hsip_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  fin_req_t    req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  logic       s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  fin_req_t   s1_q;
  sip_state_t s2_q, s2_d, s3_q, s3_d, s4_st;
  logic [31:0] hash_q;
  logic       out_ready, s3_ready, s2_ready, s1_ready;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s3_ready  = !s3_valid_q || out_ready;
  assign s2_ready  = !s2_valid_q || s3_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign req_ready_o = s1_ready;

  always_comb begin
    sip_state_t t;
    s2_d = s1_q.extra ? sip_compress(s1_q.st, len_block(s1_q.len)) : s1_q.st;
    t = s2_q;
    t.v2 = t.v2 ^ FIN_XOR;
    s3_d = sip_double(t);
    s4_st = sip_double(s3_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_q  <= req_valid_i;
      if (s2_ready)  s2_valid_q  <= s1_valid_q;
      if (s3_ready)  s3_valid_q  <= s2_valid_q;
      if (out_ready) out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && req_valid_i) s1_q   <= req_i;
    if (s2_ready && s1_valid_q)  s2_q   <= s2_d;
    if (s3_ready && s2_valid_q)  s3_q   <= s3_d;
    if (out_ready && s3_valid_q) hash_q <= s4_st.v1 ^ s4_st.v3;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

// File: hw/rtl/half_siphash_2_4_mac.sv
// HalfSipHash-2-4 keyed MAC, 32-bit tag, streaming top level.
// Takes one little-endian message word per cycle while in_stall_o is low. Each transfer lands
// in an input register, then the absorb stage runs one compression (two SipRounds) against the
// running state; that feedback loop sets the rate of one word per clock. The key is sampled on
// the first word of each message. Last words leave the loop into a three-stage finalisation
// pipeline, from whose last stage the tag passes into the output register. A waiting tag does
// not hold up intake until every stage behind it is full, and then it stalls only a last word.
module half_siphash_2_4_mac import hsip_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  logic [31:0] key_low_q, key_high_q;
  logic        in_valid_q;
  logic [31:0] word_q;
  logic [2:0]  count_q;
  logic        last_q;
  sip_state_t  st_q, st_start, st_abs;
  logic [7:0]  len_q, len_base, len_full, len_fin;
  logic        in_msg_q;
  logic        full;
  logic [23:0] tail_mask;
  logic [31:0] block;
  logic        fin_ready, absorb, in_take;
  fin_req_t    fin_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign absorb     = in_valid_q && (!last_q || fin_ready);
  assign in_stall_o = in_valid_q && !absorb;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_msg_q) begin
      st_start = st_q;
      len_base = len_q;
    end else begin
      st_start.v0 = key_low_q;
      st_start.v1 = key_high_q;
      st_start.v2 = key_low_q ^ SIP_C0;
      st_start.v3 = key_high_q ^ SIP_C1;
      len_base    = '0;
    end
    full     = !last_q || (count_q inside {[3'd4:3'd7]});
    len_full = len_base + 8'd4;
    len_fin  = full ? len_full : len_base + 8'(count_q);
    case (count_q)
      3'd1:    tail_mask = 24'h0000ff;
      3'd2:    tail_mask = 24'h00ffff;
      3'd3:    tail_mask = 24'hffffff;
      default: tail_mask = 24'h000000;
    endcase
    block   = full ? word_q : (len_block(len_fin) | 32'(word_q[23:0] & tail_mask));
    st_abs  = sip_compress(st_start, block);
    fin_req.st    = st_abs;
    fin_req.extra = full;
    fin_req.len   = len_fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_msg_q   <= 1'b0;
      st_q       <= '0;
      len_q      <= '0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (absorb) begin
        in_msg_q <= !last_q;
        st_q     <= st_abs;
        len_q    <= len_full;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      word_q  <= data_word_i;
      count_q <= byte_count_i;
      last_q  <= is_last_i;
    end
  end

  hsip_fin u_fin (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid_q && last_q),
    .req_ready_o  (fin_ready),
    .req_i        (fin_req),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

endmodule
